@@ rtl/fwn_pkg.sv @@
// Package for the fullwidth text normaliser: code point constants, ASCII
// constants and the struct that carries one mapped character between modules.
// No dependencies.
package fwn_pkg;

    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;
    localparam int BODY_N = 4;
    localparam int OUT_N  = 5;
    localparam int CNT_W  = 3;

    localparam logic [CP_W-1:0] CP_IDEO_SPACE   = 21'h003000;
    localparam logic [CP_W-1:0] CP_FW_FIRST     = 21'h00FF01;
    localparam logic [CP_W-1:0] CP_FW_LAST      = 21'h00FF5E;
    localparam logic [CP_W-1:0] CP_NUM_FIRST    = 21'h002460;
    localparam logic [CP_W-1:0] CP_NUM_LAST     = 21'h00249B;
    localparam logic [CP_W-1:0] CP_LET_FIRST    = 21'h00249C;
    localparam logic [CP_W-1:0] CP_LET_LAST     = 21'h0024E9;
    localparam logic [CP_W-1:0] CP_ZERO_A       = 21'h0024EA;
    localparam logic [CP_W-1:0] CP_NEG_FIRST    = 21'h0024EB;
    localparam logic [CP_W-1:0] CP_NEG_LAST     = 21'h0024F4;
    localparam logic [CP_W-1:0] CP_DBL_FIRST    = 21'h0024F5;
    localparam logic [CP_W-1:0] CP_DBL_LAST     = 21'h0024FE;
    localparam logic [CP_W-1:0] CP_ZERO_B       = 21'h0024FF;
    localparam logic [CP_W-1:0] CP_ASCII_SPACE  = 21'h000020;
    localparam logic [CP_W-1:0] CP_ONE_BYTE_END = 21'h000080;
    localparam logic [CP_W-1:0] CP_TWO_BYTE_END = 21'h000800;
    localparam logic [CP_W-1:0] CP_BMP_END      = 21'h010000;

    localparam logic [BYTE_W-1:0] ASCII_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] ASCII_BANG    = 8'h21;
    localparam logic [BYTE_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] ASCII_ONE     = 8'h31;
    localparam logic [BYTE_W-1:0] ASCII_TWO     = 8'h32;
    localparam logic [BYTE_W-1:0] ASCII_A_LOWER = 8'h61;

    typedef logic [BODY_N-1:0][BYTE_W-1:0] body_bytes_t;
    typedef logic [OUT_N-1:0][BYTE_W-1:0]  out_bytes_t;

    // One character after mapping, before any inserted space
    typedef struct packed {
        body_bytes_t      body;
        logic [CNT_W-1:0] len;
        logic             wide;
        logic             lit_space;
    } map_result_t;

endpackage

@@ rtl/fwn_chan_if.sv @@
// Valid/ready channel interfaces for the normaliser: code points in, UTF-8
// bytes out. Depends on fwn_pkg.
interface fwn_char_if
    import fwn_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CP_W-1:0]   code_point;
    logic              start_of_text;

    modport source (output valid, output code_point, output start_of_text, input ready);
    modport sink   (input valid, input code_point, input start_of_text, output ready);
endinterface

interface fwn_utf8_if
    import fwn_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte0;
    logic [BYTE_W-1:0] out_byte1;
    logic [BYTE_W-1:0] out_byte2;
    logic [BYTE_W-1:0] out_byte3;
    logic [BYTE_W-1:0] out_byte4;
    logic [CNT_W-1:0]  byte_count;

    modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
                    output out_byte3, output out_byte4, output byte_count, input ready);
    modport sink   (input valid, input out_byte0, input out_byte1, input out_byte2,
                    input out_byte3, input out_byte4, input byte_count, output ready);
endinterface

@@ rtl/fwn_map.sv @@
// Character mapper: folds fullwidth and enclosed forms to ASCII and encodes
// everything else as UTF-8. Purely combinational. Depends on fwn_pkg.
module fwn_map
    import fwn_pkg::*;
(
    input  logic [CP_W-1:0] code_point,
    output map_result_t     result
);

    logic [CP_W-1:0] num_diff;
    logic [CP_W-1:0] let_diff;
    logic [CP_W-1:0] neg_diff;
    logic [CP_W-1:0] dbl_diff;
    logic [5:0]      num_off;
    logic [6:0]      let_off;
    logic [6:0]      let_mod;
    logic [4:0]      dec_val;
    logic            is_dec;

    assign num_diff = code_point - CP_NUM_FIRST;
    assign let_diff = code_point - CP_LET_FIRST;
    assign neg_diff = code_point - CP_NEG_FIRST;
    assign dbl_diff = code_point - CP_DBL_FIRST;
    assign num_off  = num_diff[5:0];
    assign let_off  = let_diff[6:0];

    always_comb
    begin
        priority if (let_off >= 7'd52)
            let_mod = let_off - 7'd52;
        else if (let_off >= 7'd26)
            let_mod = let_off - 7'd26;
        else
            let_mod = let_off;
    end

    // Enclosed numbers that become a decimal value 1..20
    always_comb
    begin
        is_dec  = 1'b1;
        dec_val = 5'd1;
        priority if (code_point >= CP_NUM_FIRST && code_point <= CP_NUM_LAST)
        begin
            priority if (num_off >= 6'd40)
                dec_val = 5'(num_off - 6'd39);
            else if (num_off >= 6'd20)
                dec_val = 5'(num_off - 6'd19);
            else
                dec_val = 5'(num_off + 6'd1);
        end
        else if (code_point >= CP_NEG_FIRST && code_point <= CP_NEG_LAST)
            dec_val = 5'(neg_diff[3:0]) + 5'd11;
        else if (code_point >= CP_DBL_FIRST && code_point <= CP_DBL_LAST)
            dec_val = 5'(dbl_diff[3:0]) + 5'd1;
        else
            is_dec = 1'b0;
    end

    always_comb
    begin
        result.body = '0;
        result.len  = 3'd1;
        priority if (code_point == CP_IDEO_SPACE)
            result.body[0] = ASCII_SPACE;
        else if (code_point >= CP_FW_FIRST && code_point <= CP_FW_LAST)
            result.body[0] = BYTE_W'(code_point - CP_FW_FIRST) + ASCII_BANG;
        else if (code_point == CP_ZERO_A || code_point == CP_ZERO_B)
            result.body[0] = ASCII_ZERO;
        else if (is_dec)
        begin
            priority if (dec_val >= 5'd20)
            begin
                result.body[0] = ASCII_TWO;
                result.body[1] = ASCII_ZERO;
                result.len     = 3'd2;
            end
            else if (dec_val >= 5'd10)
            begin
                result.body[0] = ASCII_ONE;
                result.body[1] = ASCII_ZERO + BYTE_W'(dec_val - 5'd10);
                result.len     = 3'd2;
            end
            else
                result.body[0] = ASCII_ZERO + BYTE_W'(dec_val);
        end
        else if (code_point >= CP_LET_FIRST && code_point <= CP_LET_LAST)
        begin
            result.body[0] = ASCII_A_LOWER + BYTE_W'(let_mod);
            result.body[1] = ASCII_SPACE;
            result.len     = 3'd2;
        end
        else if (code_point < CP_ONE_BYTE_END)
            result.body[0] = code_point[7:0];
        else if (code_point < CP_TWO_BYTE_END)
        begin
            result.body[0] = {3'b110, code_point[10:6]};
            result.body[1] = {2'b10, code_point[5:0]};
            result.len     = 3'd2;
        end
        else if (code_point < CP_BMP_END)
        begin
            result.body[0] = {4'b1110, code_point[15:12]};
            result.body[1] = {2'b10, code_point[11:6]};
            result.body[2] = {2'b10, code_point[5:0]};
            result.len     = 3'd3;
        end
        else
        begin
            result.body[0] = {5'b11110, code_point[20:18]};
            result.body[1] = {2'b10, code_point[17:12]};
            result.body[2] = {2'b10, code_point[11:6]};
            result.body[3] = {2'b10, code_point[5:0]};
            result.len     = 3'd4;
        end
        result.wide      = (result.len >= 3'd3);
        result.lit_space = (code_point == CP_ASCII_SPACE);
    end

endmodule

@@ rtl/fullwidth_ascii_text_normalizer.sv @@
// Top level of the fullwidth text normaliser: input register, mapper, space
// insertion and result register. Depends on fwn_pkg, fwn_chan_if, fwn_map.
//
//  channel | dir | handshake   | payload
//  chars   | in  | valid/ready | code_point[20:0], start_of_text
//  utf8    | out | valid/ready | out_byte0..out_byte4[7:0], byte_count[2:0]
//
// One code point per cycle unless the result stalls; an accepted item passes the
// input register, the mapper and the result register. The width memory of
// the previous character updates as an item moves across the mapper.
// rst_n clears both valid flags and the previous-character memory.
// A stalled result holds the input register; chars.ready drops only when both
// registers are full and utf8.ready is low.
module fullwidth_ascii_text_normalizer
    import fwn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    fwn_char_if.sink  chars,
    fwn_utf8_if.source utf8
);

    logic             in_valid_reg;
    logic [CP_W-1:0]  in_cp_reg;
    logic             in_sot_reg;
    logic             out_valid_reg;
    out_bytes_t       out_bytes_reg;
    out_bytes_t       out_bytes_next;
    logic [CNT_W-1:0] out_count_reg;
    logic [CNT_W-1:0] out_count_next;
    logic             have_prev_reg;
    logic             prev_wide_reg;
    logic             prev_space_reg;
    logic             advance;
    logic             load;
    logic             insert;
    map_result_t      mapped;

    fwn_map u_map
    (
        .code_point (in_cp_reg),
        .result     (mapped)
    );

    assign advance     = in_valid_reg && (!out_valid_reg || utf8.ready);
    assign chars.ready = !in_valid_reg || advance;
    assign load        = chars.valid && chars.ready;

    // Space at a switch between wide and narrow output, except at start of text or beside a literal space
    assign insert = have_prev_reg && !in_sot_reg &&
                    ((!prev_wide_reg && mapped.wide && !prev_space_reg) ||
                     (prev_wide_reg && !mapped.wide && !mapped.lit_space));

    always_comb
    begin
        if (insert)
        begin
            out_bytes_next = {mapped.body, ASCII_SPACE};
            out_count_next = mapped.len + 3'd1;
        end
        else
        begin
            out_bytes_next = {8'h00, mapped.body};
            out_count_next = mapped.len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            have_prev_reg  <= 1'b0;
            prev_wide_reg  <= 1'b0;
            prev_space_reg <= 1'b0;
        end
        else
        begin
            if (chars.ready)
                in_valid_reg <= chars.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (utf8.ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                have_prev_reg  <= 1'b1;
                prev_wide_reg  <= mapped.wide;
                prev_space_reg <= mapped.lit_space;
            end
        end
    end

    // Payload registers: hold unless a transaction moves
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_cp_reg  <= chars.code_point;
            in_sot_reg <= chars.start_of_text;
        end
        if (advance)
        begin
            out_bytes_reg <= out_bytes_next;
            out_count_reg <= out_count_next;
        end
    end

    assign utf8.valid      = out_valid_reg;
    assign utf8.out_byte0  = out_bytes_reg[0];
    assign utf8.out_byte1  = out_bytes_reg[1];
    assign utf8.out_byte2  = out_bytes_reg[2];
    assign utf8.out_byte3  = out_bytes_reg[3];
    assign utf8.out_byte4  = out_bytes_reg[4];
    assign utf8.byte_count = out_count_reg;

endmodule

@@ rtl/fwn_check.sv @@
// Port-level checker for the fullwidth text normaliser, bound to the top
// level. Depends on fwn_pkg and the top level's channel interfaces.
module fwn_check
    import fwn_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              chars_ready,
    input logic              utf8_valid,
    input logic              utf8_ready,
    input logic [BYTE_W-1:0] out_byte0,
    input logic [BYTE_W-1:0] out_byte4,
    input logic [CNT_W-1:0]  byte_count
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !utf8_valid)
        else $error("result valid during reset");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        utf8_valid |-> (byte_count >= 3'd1 && byte_count <= 3'd5))
        else $error("byte_count out of range");

    // Five bytes only with an inserted space in front of a four-byte form
    a_five_space: assert property (@(posedge clk) disable iff (!rst_n)
        (utf8_valid && byte_count == 3'd5) |-> out_byte0 == ASCII_SPACE)
        else $error("five-byte result without leading space");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (utf8_valid && byte_count != 3'd5) |-> out_byte4 == 8'h00)
        else $error("unused fifth byte not zero");

    // A draining output never blocks the input side
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        utf8_ready |-> chars_ready)
        else $error("input stalled while output drains");

endmodule

bind fullwidth_ascii_text_normalizer fwn_check u_fwn_check
(
    .clk         (clk),
    .rst_n       (rst_n),
    .chars_ready (chars.ready),
    .utf8_valid  (utf8.valid),
    .utf8_ready  (utf8.ready),
    .out_byte0   (utf8.out_byte0),
    .out_byte4   (utf8.out_byte4),
    .byte_count  (utf8.byte_count)
);

@@ verif/fullwidth_ascii_text_normalizer_tb.sv @@
// Self-checking testbench for fullwidth_ascii_text_normalizer: a table of directed code
// points, then random text, checked against a predictor of the UTF-8 output bytes.
// Depends on fwn_pkg, fwn_char_if, fwn_utf8_if and the normaliser RTL.
module fullwidth_ascii_text_normalizer_tb
    import fwn_pkg::*;
();

    localparam int RANDOM_ITEMS  = 500;
    localparam int CALM_ITEMS    = 80;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int WALK_N        = 25;

    typedef struct packed {
        out_bytes_t       bytes;
        logic [CNT_W-1:0] count;
    } utf8_bytes_t;

    // Directed row: a code point and, where obvious, its output typed in
    typedef struct packed {
        logic [CP_W-1:0]   cp;
        logic              sot;
        logic              typed;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
        logic [CNT_W-1:0]  count;
    } glyph_row_t;

    localparam glyph_row_t WALK_ROWS [WALK_N] = '{
        '{21'h000000, 1'b1, 1'b1, 8'h00,         8'h00,       3'd1},
        '{CP_IDEO_SPACE, 1'b0, 1'b1, ASCII_SPACE, 8'h00,      3'd1},
        '{CP_FW_FIRST,   1'b0, 1'b1, ASCII_BANG,  8'h00,      3'd1},
        '{CP_FW_LAST,    1'b0, 1'b1, 8'h7E,       8'h00,      3'd1},
        '{CP_NUM_FIRST,  1'b0, 1'b1, ASCII_ONE,   8'h00,      3'd1},
        '{CP_NUM_LAST,   1'b0, 1'b1, ASCII_TWO,   ASCII_ZERO, 3'd2},
        '{CP_LET_FIRST,  1'b0, 1'b1, ASCII_A_LOWER, ASCII_SPACE, 3'd2},
        '{CP_LET_LAST,   1'b0, 1'b1, 8'h7A,       ASCII_SPACE, 3'd2},
        '{CP_ZERO_A,     1'b0, 1'b1, ASCII_ZERO,  8'h00,      3'd1},
        '{CP_NEG_FIRST,  1'b0, 1'b1, ASCII_ONE,   ASCII_ONE,  3'd2},
        '{CP_NEG_LAST,   1'b0, 1'b0, 8'h00,       8'h00,      3'd0},
        '{CP_DBL_FIRST,  1'b0, 1'b1, ASCII_ONE,   8'h00,      3'd1},
        '{CP_DBL_LAST,   1'b0, 1'b1, ASCII_ONE,   ASCII_ZERO, 3'd2},
        '{CP_ZERO_B,     1'b0, 1'b1, ASCII_ZERO,  8'h00,      3'd1},
        '{21'h00AC00,    1'b0, 1'b0, 8'h00,       8'h00,      3'd0},
        '{21'h000041,    1'b0, 1'b0, 8'h00,       8'h00,      3'd0},
        '{CP_ASCII_SPACE, 1'b0, 1'b0, 8'h00,      8'h00,      3'd0},
        '{21'h004E00,    1'b0, 1'b0, 8'h00,       8'h00,      3'd0},
        '{CP_ASCII_SPACE, 1'b0, 1'b0, 8'h00,      8'h00,      3'd0},
        '{21'h10FFFF,    1'b1, 1'b0, 8'h00,       8'h00,      3'd0},
        '{21'h00007F,    1'b0, 1'b0, 8'h00,       8'h00,      3'd0},
        '{21'h0007FF,    1'b0, 1'b0, 8'h00,       8'h00,      3'd0},
        '{21'h00D800,    1'b0, 1'b0, 8'h00,       8'h00,      3'd0},
        '{21'h1FFFFF,    1'b0, 1'b0, 8'h00,       8'h00,      3'd0},
        '{21'h000080,    1'b0, 1'b0, 8'h00,       8'h00,      3'd0}
    };

    logic clk;
    logic rst_n;

    fwn_char_if chars_if ();
    fwn_utf8_if utf8_if ();

    fullwidth_ascii_text_normalizer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars_if),
        .utf8  (utf8_if)
    );

    // Predictor state: memory of the previous character
    logic seen_char;
    logic last_wide;
    logic last_was_space;

    utf8_bytes_t utf8_due_q [$];
    utf8_bytes_t want;
    utf8_bytes_t got;

    // Typed-in expectation of the row on the bus, set with the payload
    logic              row_typed;
    logic [BYTE_W-1:0] row_b0;
    logic [BYTE_W-1:0] row_b1;
    logic [CNT_W-1:0]  row_count;

    logic calm;
    int   fault_cnt;
    int   chars_sent;
    int   results_checked;
    int   quiet_cycles;
    logic got_any;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_fault(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fault_cnt++;
    endtask

    function automatic int unsigned decimal_glyph(input int unsigned num, output body_bytes_t body);
        body = '0;
        if (num >= 10)
        begin
            body[0] = ASCII_ZERO + 8'(num / 10);
            body[1] = ASCII_ZERO + 8'(num % 10);
            return 2;
        end
        body[0] = ASCII_ZERO + 8'(num);
        return 1;
    endfunction

    // Mapped bytes of one code point, before any inserted space
    function automatic int unsigned map_glyph(input logic [CP_W-1:0] cp, output body_bytes_t body);
        int unsigned v;
        v = cp;
        body = '0;
        if (cp == CP_IDEO_SPACE)
        begin
            body[0] = ASCII_SPACE;
            return 1;
        end
        if (cp >= CP_FW_FIRST && cp <= CP_FW_LAST)
        begin
            body[0] = ASCII_BANG + 8'(v - CP_FW_FIRST);
            return 1;
        end
        if (cp == CP_ZERO_A || cp == CP_ZERO_B)
        begin
            body[0] = ASCII_ZERO;
            return 1;
        end
        if (cp >= CP_NUM_FIRST && cp <= CP_NUM_LAST)
            return decimal_glyph((v - CP_NUM_FIRST) % 20 + 1, body);
        if (cp >= CP_LET_FIRST && cp <= CP_LET_LAST)
        begin
            body[0] = ASCII_A_LOWER + 8'((v - CP_LET_FIRST) % 26);
            body[1] = ASCII_SPACE;
            return 2;
        end
        if (cp >= CP_NEG_FIRST && cp <= CP_NEG_LAST)
            return decimal_glyph(v - CP_NEG_FIRST + 11, body);
        // Double-circled one to ten start at one, not at the negative-circled offset
        if (cp >= CP_DBL_FIRST && cp <= CP_DBL_LAST)
            return decimal_glyph(v - CP_DBL_FIRST + 1, body);
        if (cp < CP_ONE_BYTE_END)
        begin
            body[0] = 8'(v);
            return 1;
        end
        if (cp < CP_TWO_BYTE_END)
        begin
            body[0] = 8'hC0 | 8'(v >> 6);
            body[1] = 8'h80 | 8'(v & 'h3F);
            return 2;
        end
        if (cp < CP_BMP_END)
        begin
            body[0] = 8'hE0 | 8'(v >> 12);
            body[1] = 8'h80 | 8'((v >> 6) & 'h3F);
            body[2] = 8'h80 | 8'(v & 'h3F);
            return 3;
        end
        // Above the BMP, including values past the Unicode range: lead byte from bits 20:18
        body[0] = 8'hF0 | 8'((v >> 18) & 'h07);
        body[1] = 8'h80 | 8'((v >> 12) & 'h3F);
        body[2] = 8'h80 | 8'((v >> 6) & 'h3F);
        body[3] = 8'h80 | 8'(v & 'h3F);
        return 4;
    endfunction

    function automatic utf8_bytes_t normalise_char(input logic [CP_W-1:0] cp, input logic sot);
        body_bytes_t body;
        int unsigned n;
        int unsigned k;
        int unsigned i;
        logic        wide;
        logic        space_now;
        logic        gap;
        utf8_bytes_t r;
        n         = map_glyph(cp, body);
        wide      = (n >= 3);
        space_now = (cp == CP_ASCII_SPACE);
        gap = seen_char && !sot &&
              ((!last_wide && wide && !last_was_space) || (last_wide && !wide && !space_now));
        r = '0;
        k = 0;
        if (gap)
        begin
            r.bytes[0] = ASCII_SPACE;
            k = 1;
        end
        for (i = 0; i < n; i++)
        begin
            r.bytes[k] = body[i];
            k++;
        end
        r.count = CNT_W'(k);
        seen_char      = 1'b1;
        last_wide      = wide;
        last_was_space = space_now;
        return r;
    endfunction

    // Scoreboard: predict on each input transaction, check each output transaction
    always @(posedge clk)
    begin
        got_any = 1'b0;
        if (rst_n && chars_if.valid && chars_if.ready)
        begin
            want = normalise_char(chars_if.code_point, chars_if.start_of_text);
            if (row_typed)
            begin
                want = '0;
                want.bytes[0] = row_b0;
                want.bytes[1] = row_b1;
                want.count    = row_count;
            end
            utf8_due_q.push_back(want);
            got_any = 1'b1;
        end
        if (rst_n && utf8_if.valid && utf8_if.ready)
        begin
            got.bytes = {utf8_if.out_byte4, utf8_if.out_byte3, utf8_if.out_byte2,
                         utf8_if.out_byte1, utf8_if.out_byte0};
            got.count = utf8_if.byte_count;
            got_any = 1'b1;
            if (utf8_due_q.size() == 0)
                report_fault($sformatf("result with nothing pending, byte_count %0d", got.count));
            else
            begin
                want = utf8_due_q.pop_front();
                if (got.count !== want.count)
                    report_fault($sformatf("result %0d byte_count: got %0d, expected %0d",
                                           results_checked, got.count, want.count));
                for (int i = 0; i < OUT_N; i++)
                    if (got.bytes[i] !== want.bytes[i])
                        report_fault($sformatf("result %0d out_byte%0d: got 0x%02h, expected 0x%02h",
                                               results_checked, i, got.bytes[i], want.bytes[i]));
                results_checked++;
            end
        end
        quiet_cycles = got_any ? 0 : quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Timed out with %0d results still pending", utf8_due_q.size());
        $display("FAILED: results differ");
        $finish;
    end

    // Result side: stall in random bursts, none once the run turns calm
    initial
    begin
        int burst;
        burst = 0;
        utf8_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm)
                utf8_if.ready <= 1'b1;
            else if (burst > 0)
            begin
                utf8_if.ready <= 1'b0;
                burst--;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                utf8_if.ready <= 1'b0;
                burst = $urandom_range(1, 6) - 1;
            end
            else
                utf8_if.ready <= 1'b1;
        end
    end

    task automatic send_char(input logic [CP_W-1:0] cp, input logic sot, input logic typed,
                             input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                             input logic [CNT_W-1:0] cnt);
        // On a random quarter of sends, insert a gap first, unless the run has turned calm
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        chars_if.valid         <= 1'b1;
        chars_if.code_point    <= cp;
        chars_if.start_of_text <= sot;
        row_typed <= typed;
        row_b0    <= b0;
        row_b1    <= b1;
        row_count <= cnt;
        do
            @(posedge clk);
        while (!chars_if.ready);
        @(negedge clk);
        chars_sent++;
    endtask

    function automatic logic [CP_W-1:0] pick_code_point();
        case ($urandom_range(0, 11))
            0:       return CP_W'($urandom_range(0, 'h7F));
            1:       return CP_ASCII_SPACE;
            2:       return CP_IDEO_SPACE;
            3:       return CP_W'($urandom_range('hFF00, 'hFF5F));
            4, 5:    return CP_W'($urandom_range('h245F, 'h2500));
            6:       return CP_W'($urandom_range('h80, 'h7FF));
            7:       return CP_W'($urandom_range('h4E00, 'h9FFF));
            8:       return CP_W'($urandom_range('h800, 'hFFFF));
            9:       return CP_W'($urandom_range('h10000, 'h10FFFF));
            10:      return CP_W'($urandom);
            default: return CP_W'($urandom_range('h41, 'h7A));
        endcase
    endfunction

    initial
    begin
        rst_n                  = 1'b0;
        chars_if.valid         = 1'b0;
        chars_if.code_point    = '0;
        chars_if.start_of_text = 1'b0;
        row_typed = 1'b0;
        row_b0    = '0;
        row_b1    = '0;
        row_count = '0;
        calm            = 1'b0;
        fault_cnt       = 0;
        chars_sent      = 0;
        results_checked = 0;
        quiet_cycles    = 0;
        seen_char       = 1'b0;
        last_wide       = 1'b0;
        last_was_space  = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < WALK_N; r++)
            send_char(WALK_ROWS[r].cp, WALK_ROWS[r].sot, WALK_ROWS[r].typed,
                      WALK_ROWS[r].b0, WALK_ROWS[r].b1, WALK_ROWS[r].count);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            send_char(pick_code_point(), $urandom_range(0, 15) == 0, 1'b0, '0, '0, '0);
        end
        chars_if.valid <= 1'b0;

        while (utf8_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d code points (%0d directed, rest random across all ranges)",
                 chars_sent, WALK_N);
        $display("Checked %0d results, %0d mismatches", results_checked, fault_cnt);
        if (fault_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/fwn_pkg.sv
rtl/fwn_chan_if.sv
rtl/fwn_map.sv
rtl/fullwidth_ascii_text_normalizer.sv
rtl/fwn_check.sv
verif/fullwidth_ascii_text_normalizer_tb.sv
